[design/dcf_slot_backoff_engine_core_macros.svh]
// Assertion macros for the slot backoff engine checker.
// Clocked on aclk, disabled while aresetn is low.
`ifndef DCF_SLOT_BACKOFF_ENGINE_CORE_MACROS_SVH
`define DCF_SLOT_BACKOFF_ENGINE_CORE_MACROS_SVH

// condition holds in the same cycle
`define DCFSB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dcfsb check failed");

// condition holds in the following cycle
`define DCFSB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dcfsb check failed");

`endif

[design/dcfsb_pkg.sv]
// Shared types and constants of the slot backoff engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcfsb_pkg;

    localparam int STATIONS_DEF = 8;

    localparam int CW_W      = 10;
    localparam int RETRY_W   = 4;
    localparam int SEED_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int OUTC_W = 2;
    localparam int TX_W   = 4;
    localparam int WIN_W  = 3;
    localparam int MASK_W = 8;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CW_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CW_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LFSR_SEED  = 2'd3;

    localparam logic [OUTC_W-1:0] OUT_IDLE    = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_SUCCESS = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_COLLIDE = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_RESTART = 2'd3;

    localparam logic [CW_W-1:0]    CW_MIN_RST     = 10'd15;
    localparam logic [CW_W-1:0]    CW_MAX_RST     = 10'd1023;
    localparam logic [RETRY_W-1:0] DROP_LIMIT_RST = 4'd7;
    localparam logic [SEED_W-1:0]  LFSR_SEED_RST  = 16'd44257;
    localparam logic [SEED_W-1:0]  LFSR_TAPS      = 16'hB400;

    typedef struct packed {
        logic               flag;
        logic [RETRY_W-1:0] retry;
        logic [CW_W-1:0]    cw;
        logic [CW_W-1:0]    backoff;
    } st_entry_t;

    localparam st_entry_t ENTRY_RST = '{flag: 1'b0, retry: '0, cw: CW_MIN_RST, backoff: '0};

    typedef struct packed {
        logic [CW_W-1:0]    cw_min;
        logic [CW_W-1:0]    cw_max;
        logic [RETRY_W-1:0] drop_limit;
        logic [SEED_W-1:0]  lfsr_seed;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
    } rng_ctl_t;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [TX_W-1:0]   transmitters;
        logic [WIN_W-1:0]  winner;
        logic [MASK_W-1:0] collided_mask;
        logic [MASK_W-1:0] dropped_mask;
    } result_t;

endpackage

`default_nettype wire

[design/dcf_slot_backoff_engine_core.sv]
// Top level of the slot backoff engine: configuration registers,
// output register, and the station memory, generator and sequencer.
// Uses dcfsb_pkg, dcfsb_mem, dcfsb_rng, dcfsb_seq.
//
// channel  | ports                                  | contents
// ---------+----------------------------------------+------------------------------
// input    | s_tvalid s_tready s_tdata[7:0]         | restart
// result   | m_tvalid m_tready m_tdata[23:0] m_tuser| counts, winner, masks; outcome
// config   | cfg_valid cfg_ready cfg_index cfg_data | register writes, always ready
//
// A slot makes two passes over the station memory, a count pass and an update pass;
// a restart writes each station once. The memory has one read and one write port.
// s_tready returns the cycle after the result moves to the output register.
// A finished result sits in the output register while the next item runs.
// aresetn is synchronous: all stations read as backoff 0, window 15, no retries.
`timescale 1ns / 1ps
`default_nettype none

module dcf_slot_backoff_engine_core #(
    parameter int STATIONS = dcfsb_pkg::STATIONS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire [dcfsb_pkg::S_TDATA_W-1:0]       s_tdata,   // [0] restart
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // [3:0] transmitters, [6:4] winner, [14:7] collided_mask, [22:15] dropped_mask
    output logic [dcfsb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [dcfsb_pkg::OUTC_W-1:0]         m_tuser,   // [1:0] outcome
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [dcfsb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [dcfsb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dcfsb_pkg::*;

    localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;

    cfg_t                  cfg_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [OUTC_W-1:0]     m_tuser_reg;

    logic                  in_fire;
    logic                  res_valid;
    logic                  res_take;
    result_t               result;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    st_entry_t             wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    st_entry_t             rd_data;
    rng_ctl_t              rng_ctl;
    logic [CW_W-1:0]       rng_window;
    logic [CW_W-1:0]       rng_draw;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign res_take  = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cw_min     <= CW_MIN_RST;
            cfg_reg.cw_max     <= CW_MAX_RST;
            cfg_reg.drop_limit <= DROP_LIMIT_RST;
            cfg_reg.lfsr_seed  <= LFSR_SEED_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CW_MIN:     cfg_reg.cw_min     <= cfg_data[CW_W-1:0];
                REG_CW_MAX:     cfg_reg.cw_max     <= cfg_data[CW_W-1:0];
                REG_DROP_LIMIT: cfg_reg.drop_limit <= cfg_data[RETRY_W-1:0];
                REG_LFSR_SEED:  cfg_reg.lfsr_seed  <= cfg_data[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_tdata_reg <= M_TDATA_W'({result.dropped_mask, result.collided_mask,
                                       result.winner, result.transmitters});
            m_tuser_reg <= result.outcome;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    dcfsb_mem #(
        .STATIONS (STATIONS),
        .IDX_W    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dcfsb_rng u_rng (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rng_ctl),
        .seed    (cfg_reg.lfsr_seed),
        .window  (rng_window),
        .draw    (rng_draw)
    );

    dcfsb_seq #(
        .STATIONS (STATIONS),
        .IDX_W    (IDX_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .restart    (s_tdata[0]),
        .in_ready   (s_tready),
        .cfg        (cfg_reg),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rng_ctl    (rng_ctl),
        .rng_window (rng_window),
        .rng_draw   (rng_draw),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .result     (result)
    );

endmodule

`default_nettype wire

[design/dcfsb_mem.sv]
// Station state memory: one write and one registered read port.
// Entries never written read as the reset entry. Uses dcfsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcfsb_mem #(
    parameter int STATIONS = dcfsb_pkg::STATIONS_DEF,
    parameter int IDX_W    = (STATIONS > 1) ? $clog2(STATIONS) : 1
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      wr_en,
    input  wire [IDX_W-1:0]          wr_addr,
    input  dcfsb_pkg::st_entry_t     wr_data,
    input  wire                      rd_en,
    input  wire [IDX_W-1:0]          rd_addr,
    output dcfsb_pkg::st_entry_t     rd_data
);
    import dcfsb_pkg::*;

    st_entry_t            mem_reg [STATIONS];
    st_entry_t            rd_data_reg;
    logic [STATIONS-1:0]  vld_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : ENTRY_RST;

endmodule

`default_nettype wire

[design/dcfsb_rng.sv]
// Galois LFSR and bounded draw of a backoff value within a window.
// Uses dcfsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcfsb_rng (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  dcfsb_pkg::rng_ctl_t           ctl,
    input  wire [dcfsb_pkg::SEED_W-1:0]   seed,
    input  wire [dcfsb_pkg::CW_W-1:0]     window,
    output logic [dcfsb_pkg::CW_W-1:0]    draw
);
    import dcfsb_pkg::*;

    logic [SEED_W-1:0] lfsr_reg;
    logic [SEED_W-1:0] lfsr_next;
    logic [SEED_W-1:0] stepped;
    logic [CW_W-1:0]   mask;
    logic [CW_W-1:0]   val;

    always_comb begin
        stepped = {1'b0, lfsr_reg[SEED_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        mask    = window;
        mask    = mask | (mask >> 1);
        mask    = mask | (mask >> 2);
        mask    = mask | (mask >> 4);
        mask    = mask | (mask >> 8);
        val     = stepped[CW_W-1:0] & mask;
        if (val > window) begin
            draw = val - window - CW_W'(1);
        end else begin
            draw = val;
        end
        if (ctl.load) begin
            lfsr_next = seed;
        end else if (ctl.step) begin
            lfsr_next = stepped;
        end else begin
            lfsr_next = lfsr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= LFSR_SEED_RST;
        end else begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

`default_nettype wire

[design/dcfsb_seq.sv]
// Slot sequencer: counts zero counters in one memory pass, then
// reads, updates and writes back each station; a restart resets all. Uses dcfsb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcfsb_seq #(
    parameter int STATIONS = dcfsb_pkg::STATIONS_DEF,
    parameter int IDX_W    = (STATIONS > 1) ? $clog2(STATIONS) : 1
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_fire,
    input  wire                            restart,
    output logic                           in_ready,
    input  dcfsb_pkg::cfg_t                cfg,
    output logic                           wr_en,
    output logic [IDX_W-1:0]               wr_addr,
    output dcfsb_pkg::st_entry_t           wr_data,
    output logic                           rd_en,
    output logic [IDX_W-1:0]               rd_addr,
    input  dcfsb_pkg::st_entry_t           rd_data,
    output dcfsb_pkg::rng_ctl_t            rng_ctl,
    output logic [dcfsb_pkg::CW_W-1:0]     rng_window,
    input  wire [dcfsb_pkg::CW_W-1:0]      rng_draw,
    output logic                           res_valid,
    input  wire                            res_take,
    output dcfsb_pkg::result_t             result
);
    import dcfsb_pkg::*;

    localparam int CNT_W = $clog2(STATIONS + 1);
    localparam int XW    = (IDX_W > WIN_W) ? IDX_W : WIN_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(STATIONS - 1);

    typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_UPD, ST_RST, ST_DONE} state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   iss_reg, iss_next;
    logic               iss_on_reg, iss_on_next;
    logic               dv_reg, dv_next;
    logic [IDX_W-1:0]   dix_reg, dix_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   first_reg, first_next;
    logic [OUTC_W-1:0]  outcome_reg, outcome_next;
    logic [MASK_W-1:0]  cmask_reg, cmask_next;
    logic [MASK_W-1:0]  dmask_reg, dmask_next;

    logic               issuing;
    logic               zero;
    logic [RETRY_W:0]   n_retry;
    logic               drop;
    logic [CW_W:0]      dbl;
    logic [CW_W-1:0]    capped;
    logic               upd_hit;
    logic               do_reset;
    logic [MASK_W-1:0]  bitsel;
    logic [XW-1:0]      first_x;
    st_entry_t          e;

    always_comb begin
        e       = rd_data;
        issuing = (state_reg == ST_SCAN || state_reg == ST_UPD) && iss_on_reg;
        zero    = (e.backoff == '0);
        n_retry = {1'b0, e.retry} + (RETRY_W+1)'(1);
        drop    = (n_retry >= {1'b0, cfg.drop_limit});
        dbl     = {e.cw, 1'b1};
        capped  = (dbl > {1'b0, cfg.cw_max}) ? cfg.cw_max : dbl[CW_W-1:0];
        upd_hit = (state_reg == ST_UPD) && dv_reg && zero && (cnt_reg != '0);
        do_reset = (state_reg == ST_RST) || (upd_hit && (cnt_reg == CNT_W'(1) || drop));

        for (int i = 0; i < MASK_W; i++) begin
            bitsel[i] = (XW'(dix_reg) == XW'(i));
        end

        rd_en        = issuing;
        rd_addr      = iss_reg;
        rng_window   = do_reset ? cfg.cw_min : capped;
        rng_ctl.load = in_fire && restart;
        rng_ctl.step = (state_reg == ST_RST) || upd_hit;

        wr_en   = 1'b0;
        wr_addr = dix_reg;
        wr_data = e;
        if (state_reg == ST_RST) begin
            wr_en   = 1'b1;
            wr_addr = iss_reg;
        end else if (state_reg == ST_UPD && dv_reg) begin
            wr_en = 1'b1;
        end
        if (do_reset) begin
            wr_data = '{flag: 1'b0, retry: '0, cw: cfg.cw_min, backoff: rng_draw};
        end else if (upd_hit) begin
            wr_data = '{flag: 1'b1, retry: n_retry[RETRY_W-1:0], cw: capped, backoff: rng_draw};
        end else if (cnt_reg == '0) begin
            wr_data.backoff = e.backoff - CW_W'(1);
        end

        state_next   = state_reg;
        iss_next     = iss_reg;
        iss_on_next  = iss_on_reg;
        dv_next      = 1'b0;
        dix_next     = dix_reg;
        cnt_next     = cnt_reg;
        first_next   = first_reg;
        outcome_next = outcome_reg;
        cmask_next   = cmask_reg;
        dmask_next   = dmask_reg;

        if (issuing) begin
            iss_on_next = (iss_reg != LAST);
            iss_next    = iss_reg + IDX_W'(1);
            dv_next     = 1'b1;
            dix_next    = iss_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cnt_next     = '0;
                    first_next   = '0;
                    cmask_next   = '0;
                    dmask_next   = '0;
                    iss_next     = '0;
                    iss_on_next  = 1'b1;
                    outcome_next = OUT_RESTART;
                    state_next   = restart ? ST_RST : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (dv_reg) begin
                    if (zero) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (cnt_reg == '0) begin
                            first_next = dix_reg;
                        end
                    end
                    if (dix_reg == LAST) begin
                        iss_next    = '0;
                        iss_on_next = 1'b1;
                        state_next  = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                if (upd_hit && cnt_reg != CNT_W'(1)) begin
                    cmask_next = cmask_reg | bitsel;
                    if (drop) begin
                        dmask_next = dmask_reg | bitsel;
                    end
                end
                if (dv_reg && dix_reg == LAST) begin
                    if (cnt_reg == '0) begin
                        outcome_next = OUT_IDLE;
                    end else if (cnt_reg == CNT_W'(1)) begin
                        outcome_next = OUT_SUCCESS;
                    end else begin
                        outcome_next = OUT_COLLIDE;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_RST: begin
                iss_next = iss_reg + IDX_W'(1);
                if (iss_reg == LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iss_reg     <= '0;
            iss_on_reg  <= 1'b0;
            dv_reg      <= 1'b0;
            dix_reg     <= '0;
            cnt_reg     <= '0;
            first_reg   <= '0;
            outcome_reg <= OUT_IDLE;
            cmask_reg   <= '0;
            dmask_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            iss_reg     <= iss_next;
            iss_on_reg  <= iss_on_next;
            dv_reg      <= dv_next;
            dix_reg     <= dix_next;
            cnt_reg     <= cnt_next;
            first_reg   <= first_next;
            outcome_reg <= outcome_next;
            cmask_reg   <= cmask_next;
            dmask_reg   <= dmask_next;
        end
    end

    always_comb begin
        first_x              = XW'(first_reg);
        in_ready             = (state_reg == ST_IDLE);
        res_valid            = (state_reg == ST_DONE);
        result.outcome       = outcome_reg;
        result.transmitters  = TX_W'(cnt_reg);
        result.winner        = (outcome_reg == OUT_SUCCESS) ? first_x[WIN_W-1:0] : '0;
        result.collided_mask = cmask_reg;
        result.dropped_mask  = dmask_reg;
    end

endmodule

`default_nettype wire

[design/dcfsb_chk.sv]
// Port-level checker for the slot backoff engine, bound to the top level.
// Uses dcfsb_pkg and dcf_slot_backoff_engine_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dcf_slot_backoff_engine_core_macros.svh"

module dcfsb_chk (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [dcfsb_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire [dcfsb_pkg::OUTC_W-1:0]        m_tuser
);
    import dcfsb_pkg::*;

    logic [TX_W-1:0]   m_tx;
    logic [WIN_W-1:0]  m_win;
    logic [MASK_W-1:0] m_cmask;
    logic [MASK_W-1:0] m_dmask;
    logic              m_quiet;

    assign m_tx    = m_tdata[TX_W-1:0];
    assign m_win   = m_tdata[TX_W +: WIN_W];
    assign m_cmask = m_tdata[TX_W+WIN_W +: MASK_W];
    assign m_dmask = m_tdata[TX_W+WIN_W+MASK_W +: MASK_W];
    assign m_quiet = (m_tuser == OUT_RESTART) || (m_tuser == OUT_IDLE);

    `DCFSB_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready)

    `DCFSB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    `DCFSB_ASSERT_NOW(a_quiet_result, m_tvalid && m_quiet, m_tdata == '0)

    `DCFSB_ASSERT_NOW(a_success, m_tvalid && m_tuser == OUT_SUCCESS, m_tx == TX_W'(1) && m_cmask == '0 && m_dmask == '0)

    `DCFSB_ASSERT_NOW(a_collide, m_tvalid && m_tuser == OUT_COLLIDE, (m_dmask & ~m_cmask) == '0 && m_win == '0)

endmodule

bind dcf_slot_backoff_engine_core dcfsb_chk u_dcfsb_chk (.*);

`default_nettype wire
